// ----- src/char_lcd_nibble_sequencer_core_defines.svh -----
// Assertion macros used by the checker file of the LCD nibble sequencer.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCDNS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcdns assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCDNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcdns assertion failed");

`endif

// ----- src/lcdns_pkg.sv -----
package lcdns_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned HOLD_W    = 14;
  localparam int unsigned COLUMN_W  = 4;
  localparam int unsigned STEP_W    = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_NIBBLE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHAR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd4;

  localparam logic [HOLD_W-1:0] ENABLE_PULSE_US  = 14'd1;
  localparam logic [HOLD_W-1:0] CHAR_SETTLE_US   = 14'd46;
  localparam logic [HOLD_W-1:0] CURSOR_SETTLE_US = 14'd40;
  localparam logic [HOLD_W-1:0] POWERUP_WAIT_US  = 14'd15000;
  localparam logic [HOLD_W-1:0] FIRST_WAKE_US    = 14'd4100;
  localparam logic [HOLD_W-1:0] CLEAR_SETTLE_US  = 14'd1640;
  localparam logic [HOLD_W-1:0] INIT_SETTLE_US   = 14'd40;
  localparam logic [VALUE_W-1:0] FUNCTION_SET    = 8'h28;
  localparam logic [VALUE_W-1:0] DISPLAY_ON_BYTE = 8'h0F;

  // Init sequence: the first state, four wake-up nibbles (eight states),
  // then five bytes (twenty states).
  localparam logic [STEP_W-1:0] INIT_NIB_FIRST  = 5'd1;
  localparam logic [STEP_W-1:0] INIT_NIB_LAST   = 5'd8;
  localparam logic [STEP_W-1:0] INIT_BYTE_FIRST = 5'd9;
  localparam logic [2:0]        INIT_BYTE_FINAL = 3'd4;

  typedef struct packed {
    logic load;     // capture the accepted command and restart the step count
    logic advance;  // a word was taken and more follow
    logic emit;     // a word was taken: update the pin mirror
  } lcdns_ctrl_t;

  typedef struct packed {
    logic cmd_known;  // offered command code is one the block acts on
    logic last;       // current word is the final one of its command
  } lcdns_stat_t;

  typedef struct packed {
    logic [NIB_W-1:0]  data_nibble;
    logic              reg_select;
    logic              enable;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } lcdns_word_t;

  function automatic logic [NIB_W-1:0] init_nib(input logic [1:0] idx);
    logic [NIB_W-1:0] n;
    n = (idx == 2'd3) ? 4'd2 : 4'd3;
    return n;
  endfunction

  function automatic logic [HOLD_W-1:0] init_nib_us(input logic [1:0] idx);
    logic [HOLD_W-1:0] h;
    case (idx)
      2'd0:    h = FIRST_WAKE_US;
      2'd1:    h = 14'd100;
      2'd2:    h = 14'd0;
      default: h = INIT_SETTLE_US;
    endcase
    return h;
  endfunction

  function automatic logic [VALUE_W-1:0] init_byte(input logic [2:0] idx);
    logic [VALUE_W-1:0] b;
    case (idx)
      3'd0:    b = FUNCTION_SET;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      default: b = DISPLAY_ON_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [HOLD_W-1:0] init_byte_us(input logic [2:0] idx);
    logic [HOLD_W-1:0] h;
    h = (idx == 3'd2) ? CLEAR_SETTLE_US : INIT_SETTLE_US;
    return h;
  endfunction

endpackage

// ----- src/lcdns_cmd_if.sv -----
interface lcdns_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lcdns_pkg::CMD_W-1:0]    cmd;
  logic [lcdns_pkg::VALUE_W-1:0]  value;
  logic [lcdns_pkg::HOLD_W-1:0]   delay_us;
  logic                          row;
  logic [lcdns_pkg::COLUMN_W-1:0] column;

  modport source (output valid, cmd, value, delay_us, row, column, input ready);
  modport sink   (input valid, cmd, value, delay_us, row, column, output ready);
endinterface

// ----- src/lcdns_pin_if.sv -----
interface lcdns_pin_if;
  logic                        valid;
  logic                        ready;
  logic [lcdns_pkg::NIB_W-1:0]  data_nibble;
  logic                        reg_select;
  logic                        enable;
  logic [lcdns_pkg::HOLD_W-1:0] hold_us;
  logic                        last;

  modport source (output valid, data_nibble, reg_select, enable, hold_us, last,
                  input ready);
  modport sink   (input valid, data_nibble, reg_select, enable, hold_us, last,
                  output ready);
endinterface

// ----- src/lcdns_ctrl.sv -----
module lcdns_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lcdns_pkg::lcdns_stat_t stat,
  output lcdns_pkg::lcdns_ctrl_t ctrl
);
  import lcdns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state, state_next;
  logic   in_fire, out_fire;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    ctrl.load    = in_fire;
    ctrl.emit    = out_fire;
    ctrl.advance = out_fire && !stat.last;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        // Unused command codes are swallowed without any word.
        if (in_fire && stat.cmd_known) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && stat.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/lcdns_datapath.sv -----
module lcdns_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lcdns_pkg::CMD_W-1:0]      cmd,
  input  logic [lcdns_pkg::VALUE_W-1:0]    value,
  input  logic [lcdns_pkg::HOLD_W-1:0]     delay_us,
  input  logic                             row,
  input  logic [lcdns_pkg::COLUMN_W-1:0]   column,
  input  lcdns_pkg::lcdns_ctrl_t           ctrl,
  output lcdns_pkg::lcdns_stat_t           stat,
  output lcdns_pkg::lcdns_word_t           word
);
  import lcdns_pkg::*;

  logic [CMD_W-1:0]    cmd_r;
  logic [VALUE_W-1:0]  value_r;
  logic [HOLD_W-1:0]   delay_r;
  logic                row_r;
  logic [COLUMN_W-1:0] column_r;
  logic [STEP_W-1:0]   step;
  logic [NIB_W-1:0]    pin_nibble;
  logic                pin_rs;

  logic [STEP_W-1:0]   nib_step;
  logic [STEP_W-1:0]   byte_step;
  logic [VALUE_W-1:0]  byte_v;
  logic [HOLD_W-1:0]   settle;
  logic [1:0]          phase;
  logic                fin;

  assign nib_step  = step - INIT_NIB_FIRST;
  assign byte_step = step - INIT_BYTE_FIRST;

  // Every command is walked as phases of a byte send: high nibble strobe,
  // high nibble release, low nibble strobe, low nibble release with settle.
  // A nibble send uses only the last two phases.
  always_comb begin
    byte_v = value_r;
    settle = delay_r;
    phase  = step[1:0];
    fin    = (step[1:0] == 2'b11);
    unique case (cmd_r)
      CMD_NIBBLE: begin
        byte_v = {4'h0, value_r[3:0]};
        phase  = {1'b1, step[0]};
        fin    = step[0];
      end
      CMD_BYTE: begin
      end
      CMD_CHAR: begin
        settle = CHAR_SETTLE_US;
      end
      CMD_CURSOR: begin
        byte_v = {1'b1, row_r, 2'b00, column_r};
        settle = CURSOR_SETTLE_US;
      end
      CMD_INIT: begin
        if (step <= INIT_NIB_LAST) begin
          byte_v = {4'h0, init_nib(nib_step[2:1])};
          settle = init_nib_us(nib_step[2:1]);
          phase  = {1'b1, nib_step[0]};
          fin    = 1'b0;
        end else begin
          byte_v = init_byte(byte_step[4:2]);
          settle = init_byte_us(byte_step[4:2]);
          phase  = byte_step[1:0];
          fin    = (byte_step[4:2] == INIT_BYTE_FINAL) && (byte_step[1:0] == 2'b11);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    word.data_nibble = phase[1] ? byte_v[3:0] : byte_v[7:4];
    word.reg_select  = (cmd_r == CMD_CHAR);
    word.enable      = ~phase[0];
    word.hold_us     = phase[0] ? (phase[1] ? settle : '0) : ENABLE_PULSE_US;
    word.last        = fin;
    // The init run opens by holding the present pins for the power-up wait.
    if ((cmd_r == CMD_INIT) && (step == '0)) begin
      word.data_nibble = pin_nibble;
      word.reg_select  = pin_rs;
      word.enable      = 1'b0;
      word.hold_us     = POWERUP_WAIT_US;
      word.last        = 1'b0;
    end
  end

  assign stat.cmd_known = (cmd <= CMD_INIT);
  assign stat.last      = word.last;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= cmd;
      value_r  <= value;
      delay_r  <= delay_us;
      row_r    <= row;
      column_r <= column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= '0;
      pin_nibble <= '0;
      pin_rs     <= 1'b0;
    end else begin
      if (ctrl.load) begin
        step <= '0;
      end else if (ctrl.advance) begin
        step <= step + 5'd1;
      end
      if (ctrl.emit) begin
        pin_nibble <= word.data_nibble;
        pin_rs     <= word.reg_select;
      end
    end
  end

endmodule

// ----- src/char_lcd_nibble_sequencer_core.sv -----
// Character LCD nibble sequencer for a display on a 4-bit bus.
// The cmd_ch channel takes one command word: a single nibble, a command
// byte, a data character, a cursor move or the power-up init run. The
// pin_ch channel returns one word per pin state: data nibble, register
// select, enable level, the time in microseconds that state is held, and
// a last flag on the final state of the command.
// The first pin state is valid in the cycle after the command is accepted;
// each further state follows in the cycle after the previous one is
// taken. A nibble command gives 2 words, byte, character and cursor
// commands give 4, init gives 29. Command codes 5 to 7 produce nothing.
// Only one command is in work at a time: the step counter in the datapath
// walks the words and the controller holds cmd_ch ready low until the
// last word is taken.
// When the receiver stalls, the current word holds unchanged on pin_ch.
// Reset returns the controller to idle and clears the mirror of the pin
// levels, which the init run shows in its first state.
module char_lcd_nibble_sequencer_core (
  input logic       clk,
  input logic       rst,
  lcdns_cmd_if.sink   cmd_ch,
  lcdns_pin_if.source pin_ch
);
  import lcdns_pkg::*;

  lcdns_ctrl_t ctrl;
  lcdns_stat_t stat;
  lcdns_word_t word;

  // The controller sequences handshakes, the datapath builds each word.
  lcdns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (pin_ch.valid),
    .out_ready (pin_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lcdns_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch.cmd),
    .value    (cmd_ch.value),
    .delay_us (cmd_ch.delay_us),
    .row      (cmd_ch.row),
    .column   (cmd_ch.column),
    .ctrl     (ctrl),
    .stat     (stat),
    .word     (word)
  );

  assign pin_ch.data_nibble = word.data_nibble;
  assign pin_ch.reg_select  = word.reg_select;
  assign pin_ch.enable      = word.enable;
  assign pin_ch.hold_us     = word.hold_us;
  assign pin_ch.last        = word.last;

endmodule

// ----- src/lcdns_checker.sv -----
`include "char_lcd_nibble_sequencer_core_defines.svh"

module lcdns_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [lcdns_pkg::CMD_W-1:0]    in_cmd,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lcdns_pkg::NIB_W-1:0]    out_nibble,
  input logic [lcdns_pkg::HOLD_W-1:0]   out_hold,
  input logic                           out_last
);
  import lcdns_pkg::*;

  logic in_fire, out_fire, out_stall;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;

  // A stalled word stays on the bus.
  `LCDNS_ASSERT_NEXT(a_stall_hold, clk, rst, out_stall, out_valid && $stable(out_nibble) && $stable(out_hold) && $stable(out_last))
  // A known command starts a run of words and blocks the next command.
  `LCDNS_ASSERT_NEXT(a_start_run, clk, rst, in_fire && (in_cmd <= CMD_INIT), out_valid && !in_ready)
  // Only one command is in work at a time.
  `LCDNS_ASSERT_NOW(a_one_at_a_time, clk, rst, out_valid, !in_ready)
  // The run continues until its last word and then returns to idle.
  `LCDNS_ASSERT_NEXT(a_run_cont, clk, rst, out_fire && !out_last, out_valid)
  `LCDNS_ASSERT_NEXT(a_run_end, clk, rst, out_fire && out_last, !out_valid && in_ready)

endmodule

bind char_lcd_nibble_sequencer_core lcdns_checker u_lcdns_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd_ch.valid),
  .in_ready   (cmd_ch.ready),
  .in_cmd     (cmd_ch.cmd),
  .out_valid  (pin_ch.valid),
  .out_ready  (pin_ch.ready),
  .out_nibble (pin_ch.data_nibble),
  .out_hold   (pin_ch.hold_us),
  .out_last   (pin_ch.last)
);

// ----- tb/sv/tb_char_lcd_nibble_sequencer_core.sv -----
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer_core;
  import lcdns_pkg::*;

  // Command codes that the block ignores.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 400;
  localparam int ITEMS_PER_PH  = 19;

  // Power-up run: four wake-up nibbles and five setup bytes, packed first
  // element in the most significant slot.
  localparam logic [4*NIB_W-1:0]  WAKE_NIBS = {4'd3, 4'd3, 4'd3, 4'd2};
  localparam logic [4*HOLD_W-1:0] WAKE_US   = {14'd4100, 14'd100, 14'd0, 14'd40};
  localparam logic [5*VALUE_W-1:0] SETUP_BYTES = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0F};
  localparam logic [5*HOLD_W-1:0]  SETUP_US =
    {14'd40, 14'd40, 14'd1640, 14'd40, 14'd40};

  typedef enum int {
    PH_STEADY,
    PH_SPARSE_SEND,
    PH_SLOW_SINK,
    PH_LIGHT_BOTH
  } idle_phase_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    logic [HOLD_W-1:0]   delay_us;
    logic                row;
    logic [COLUMN_W-1:0] column;
    bit                  typed;
    lcdns_word_t         first_word;
  } lcd_cmd_t;

  logic clk;
  logic rst;

  lcdns_cmd_if cmd_ch ();
  lcdns_pin_if pin_ch ();

  char_lcd_nibble_sequencer_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .pin_ch (pin_ch)
  );

  // Pin levels as last driven, as the block keeps them for the init run.
  logic [NIB_W-1:0] mirror_nib;
  logic             mirror_rs;

  lcdns_word_t pin_words_due[$];
  lcdns_word_t fresh_words[$];
  lcd_cmd_t    directed_cmds[$];

  int send_gap_pct;
  int sink_stall_pct;
  bit hold_off_req;
  int cycles;
  int failures;
  int words_checked;
  int cmds_by_code[8];

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("char_lcd_nibble_sequencer_core test failed");
      $finish;
    end
  end

  function automatic lcdns_word_t pin_word(input logic [NIB_W-1:0] nib, input logic rs,
                                           input logic en, input logic [HOLD_W-1:0] hold,
                                           input logic fin);
    lcdns_word_t w;
    w.data_nibble = nib;
    w.reg_select  = rs;
    w.enable      = en;
    w.hold_us     = hold;
    w.last        = fin;
    return w;
  endfunction

  // Every emitted pin state also moves the pin mirror.
  function automatic void due_state(input logic [NIB_W-1:0] nib, input logic rs,
                                    input logic en, input logic [HOLD_W-1:0] hold,
                                    input logic fin);
    fresh_words.push_back(pin_word(nib, rs, en, hold, fin));
    mirror_nib = nib;
    mirror_rs  = rs;
  endfunction

  function automatic void due_nibble(input logic [NIB_W-1:0] nib,
                                     input logic [HOLD_W-1:0] settle, input logic fin);
    due_state(nib, 1'b0, 1'b1, 14'd1, 1'b0);
    due_state(nib, 1'b0, 1'b0, settle, fin);
  endfunction

  // A byte goes out high nibble first, each nibble latched by a 1 us pulse.
  function automatic void due_byte(input logic [VALUE_W-1:0] b, input logic rs,
                                   input logic [HOLD_W-1:0] settle, input logic fin);
    due_state(b[7:4], rs, 1'b1, 14'd1, 1'b0);
    due_state(b[7:4], rs, 1'b0, 14'd0, 1'b0);
    due_state(b[3:0], rs, 1'b1, 14'd1, 1'b0);
    due_state(b[3:0], rs, 1'b0, settle, fin);
  endfunction

  function automatic void predict_pins(input lcd_cmd_t c);
    int i;
    case (c.cmd)
      CMD_NIBBLE: due_nibble(c.value[3:0], c.delay_us, 1'b1);
      CMD_BYTE:   due_byte(c.value, 1'b0, c.delay_us, 1'b1);
      CMD_CHAR:   due_byte(c.value, 1'b1, 14'd46, 1'b1);
      CMD_CURSOR: due_byte({1'b1, c.row, 2'b00, c.column}, 1'b0, 14'd40, 1'b1);
      CMD_INIT: begin
        due_state(mirror_nib, mirror_rs, 1'b0, 14'd15000, 1'b0);
        for (i = 0; i < 4; i++) begin
          due_nibble(WAKE_NIBS[NIB_W*(3-i) +: NIB_W], WAKE_US[HOLD_W*(3-i) +: HOLD_W],
                     1'b0);
        end
        for (i = 0; i < 5; i++) begin
          due_byte(SETUP_BYTES[VALUE_W*(4-i) +: VALUE_W],
                   1'b0, SETUP_US[HOLD_W*(4-i) +: HOLD_W], (i == 4));
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void plan_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                   input logic [HOLD_W-1:0] delay_us, input logic row,
                                   input logic [COLUMN_W-1:0] column, input bit typed = 1'b0,
                                   input lcdns_word_t first_word = '0);
    lcd_cmd_t c;
    c.cmd        = cmd;
    c.value      = value;
    c.delay_us   = delay_us;
    c.row        = row;
    c.column     = column;
    c.typed      = typed;
    c.first_word = first_word;
    directed_cmds.push_back(c);
  endfunction

  // Offer one command word and, once it is taken, queue the pin states it
  // should produce. A typed row supplies its own first pin state.
  task automatic offer_cmd(input lcd_cmd_t c);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= c.cmd;
    cmd_ch.value    <= c.value;
    cmd_ch.delay_us <= c.delay_us;
    cmd_ch.row      <= c.row;
    cmd_ch.column   <= c.column;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    fresh_words.delete();
    predict_pins(c);
    if (c.typed && fresh_words.size() != 0) fresh_words[0] = c.first_word;
    while (fresh_words.size() != 0) pin_words_due.push_back(fresh_words.pop_front());
    cmds_by_code[c.cmd]++;
  endtask

  // The receiver stalls at the rate of the current phase, except during a
  // long hold-off, which it counts out itself.
  initial begin
    int hold_left;
    hold_left = 0;
    pin_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pin_ch.ready <= 1'b0;
      end else begin
        pin_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Compare each taken pin word with the oldest expected one.
  always @(posedge clk) begin
    lcdns_word_t exp_w;
    if (!rst && pin_ch.valid && pin_ch.ready) begin
      if (pin_words_due.size() == 0) begin
        $error("pin word with none expected: nibble %h rs %b en %b hold %0d last %b",
               pin_ch.data_nibble, pin_ch.reg_select, pin_ch.enable, pin_ch.hold_us,
               pin_ch.last);
        failures++;
      end else begin
        exp_w = pin_words_due.pop_front();
        words_checked++;
        if (pin_ch.data_nibble !== exp_w.data_nibble) begin
          $error("data_nibble: expected %h, got %h", exp_w.data_nibble, pin_ch.data_nibble);
          failures++;
        end
        if (pin_ch.reg_select !== exp_w.reg_select) begin
          $error("reg_select: expected %b, got %b", exp_w.reg_select, pin_ch.reg_select);
          failures++;
        end
        if (pin_ch.enable !== exp_w.enable) begin
          $error("enable: expected %b, got %b", exp_w.enable, pin_ch.enable);
          failures++;
        end
        if (pin_ch.hold_us !== exp_w.hold_us) begin
          $error("hold_us: expected %0d, got %0d", exp_w.hold_us, pin_ch.hold_us);
          failures++;
        end
        if (pin_ch.last !== exp_w.last) begin
          $error("last: expected %b, got %b", exp_w.last, pin_ch.last);
          failures++;
        end
      end
    end
  end

  initial begin
    lcd_cmd_t c;
    int counted;
    int roll;
    idle_phase_t ph;

    rst             = 1'b1;
    cmd_ch.valid    = 1'b0;
    cmd_ch.cmd      = CMD_NIBBLE;
    cmd_ch.value    = '0;
    cmd_ch.delay_us = '0;
    cmd_ch.row      = 1'b0;
    cmd_ch.column   = '0;
    mirror_nib      = '0;
    mirror_rs       = 1'b0;
    send_gap_pct    = 0;
    sink_stall_pct  = 0;
    hold_off_req    = 1'b0;
    cycles          = 0;
    failures        = 0;
    words_checked   = 0;
    foreach (cmds_by_code[i]) cmds_by_code[i] = 0;

    // Directed commands: field extremes, every command, ignored codes, zero
    // settle time, and init runs that show the pin levels left behind.
    plan_cmd(CMD_INIT, 8'h00, 14'd0, 1'b0, 4'h0, 1'b1,
             pin_word(4'h0, 1'b0, 1'b0, 14'd15000, 1'b0));
    plan_cmd(CMD_NIBBLE, 8'hFF, 14'h3FFF, 1'b1, 4'hF, 1'b1,
             pin_word(4'hF, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_NIBBLE, 8'h00, 14'd0, 1'b0, 4'h0, 1'b1,
             pin_word(4'h0, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_NIBBLE, 8'h5A, 14'h2AAA, 1'b0, 4'h5);
    plan_cmd(CMD_BYTE, 8'h00, 14'd0, 1'b0, 4'h0, 1'b1,
             pin_word(4'h0, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_BYTE, 8'hFF, 14'h3FFF, 1'b1, 4'hF, 1'b1,
             pin_word(4'hF, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_BYTE, 8'hA5, 14'h1555, 1'b1, 4'hA);
    plan_cmd(CMD_CHAR, 8'h00, 14'h3FFF, 1'b1, 4'hF);
    plan_cmd(CMD_CHAR, 8'hFF, 14'd0, 1'b0, 4'h0, 1'b1,
             pin_word(4'hF, 1'b1, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_CHAR, 8'h41, 14'd7, 1'b0, 4'h3);
    plan_cmd(CMD_CURSOR, 8'hFF, 14'h3FFF, 1'b0, 4'h0, 1'b1,
             pin_word(4'h8, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_CURSOR, 8'h00, 14'd0, 1'b1, 4'hF, 1'b1,
             pin_word(4'hC, 1'b0, 1'b1, 14'd1, 1'b0));
    plan_cmd(CMD_CURSOR, 8'h12, 14'd3, 1'b0, 4'hF);
    plan_cmd(CMD_CURSOR, 8'h34, 14'd9, 1'b1, 4'h0);
    plan_cmd(CMD_SPARE_A, 8'hFF, 14'h3FFF, 1'b1, 4'hF);
    plan_cmd(CMD_SPARE_B, 8'h00, 14'd0, 1'b0, 4'h0);
    plan_cmd(CMD_SPARE_C, 8'hA5, 14'h2AAA, 1'b1, 4'h9);
    // After a data character the init run starts from its low nibble with
    // register select still high.
    plan_cmd(CMD_CHAR, 8'hA5, 14'd0, 1'b0, 4'h0);
    plan_cmd(CMD_INIT, 8'hFF, 14'h3FFF, 1'b1, 4'hF, 1'b1,
             pin_word(4'h5, 1'b1, 1'b0, 14'd15000, 1'b0));
    plan_cmd(CMD_CURSOR, 8'h00, 14'd0, 1'b1, 4'h7);
    plan_cmd(CMD_SPARE_A, 8'h00, 14'd0, 1'b0, 4'h0);
    plan_cmd(CMD_INIT, 8'h00, 14'd0, 1'b0, 4'h0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cmds[i]) offer_cmd(directed_cmds[i]);

    // Random commands in four idling phases. The first phase opens with a
    // long receiver hold-off while the sender keeps offering commands.
    for (int p = 0; p < 4; p++) begin
      ph = idle_phase_t'(p);
      case (ph)
        PH_STEADY:      begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        PH_SPARSE_SEND: begin send_gap_pct = 84; sink_stall_pct = 0;  end
        PH_SLOW_SINK:   begin send_gap_pct = 0;  sink_stall_pct = 84; end
        default:        begin send_gap_pct = 9;  sink_stall_pct = 9;  end
      endcase
      if (ph == PH_STEADY) hold_off_req = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PH) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) c.cmd = CMD_W'(CMD_SPARE_A + $urandom_range(0, 2));
        else if (roll < 13) c.cmd = CMD_INIT;
        else c.cmd = CMD_W'($urandom_range(CMD_NIBBLE, CMD_CURSOR));
        c.value    = VALUE_W'($urandom_range(0, 255));
        c.delay_us = ($urandom_range(0, 7) == 0) ? 14'd0 : HOLD_W'($urandom_range(0, 16383));
        c.row      = 1'($urandom_range(0, 1));
        c.column   = COLUMN_W'($urandom_range(0, 15));
        c.typed    = 1'b0;
        c.first_word = '0;
        offer_cmd(c);
        if (c.cmd <= CMD_INIT) counted++;
      end
    end

    cmd_ch.valid   <= 1'b0;
    send_gap_pct   = 0;
    sink_stall_pct = 0;
    while (pin_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    while (pin_words_due.size() != 0) begin
      c.first_word = pin_words_due.pop_front();
      $error("pin word never arrived: nibble %h hold %0d last %b",
             c.first_word.data_nibble, c.first_word.hold_us, c.first_word.last);
      failures++;
    end

    $display("Covered %0d nibble, %0d byte, %0d character, %0d cursor, %0d init commands",
             cmds_by_code[CMD_NIBBLE], cmds_by_code[CMD_BYTE], cmds_by_code[CMD_CHAR],
             cmds_by_code[CMD_CURSOR], cmds_by_code[CMD_INIT]);
    $display("and %0d ignored codes; %0d pin words compared under four idling patterns.",
             cmds_by_code[CMD_SPARE_A] + cmds_by_code[CMD_SPARE_B] +
             cmds_by_code[CMD_SPARE_C], words_checked);
    if (failures == 0) begin
      $display("char_lcd_nibble_sequencer_core test passed");
    end else begin
      $display("char_lcd_nibble_sequencer_core test failed");
    end
    $finish;
  end

endmodule
